>>> sv/wmin2d_pkg.sv
// wmin2d_pkg: shared constants and types for the window_min_2d block.
// Used by the stream interfaces and the top level; no dependencies.
`default_nettype none

package wmin2d_pkg;

    localparam int DEF_MAX_SIZE   = 1024;
    localparam int DEF_MAX_WINDOW = 16;
    localparam int DEF_VALUE_BITS = 32;

    localparam int IMG_W      = 11;
    localparam int WIN_W      = 5;
    localparam int POS_W      = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    localparam logic [IMG_W-1:0] IMG_RST = 11'd1024;
    localparam logic [WIN_W-1:0] WIN_RST = 5'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_SIZE  = 1'b0,
        CFG_WINDOW_SIZE = 1'b1
    } t_cfg_reg;

endpackage

`default_nettype wire

>>> sv/wmin2d_pix_if.sv
// wmin2d_pix_if: pixel stream channel (valid/ready plus pixel beat payload).
// Depends on wmin2d_pkg.
`default_nettype none

interface wmin2d_pix_if #(
    parameter int VB = wmin2d_pkg::DEF_VALUE_BITS
);
    logic                 valid;
    logic                 ready;
    logic signed [VB-1:0] pixel;
    logic                 frame_start;

    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

`default_nettype wire

>>> sv/wmin2d_win_if.sv
// wmin2d_win_if: window result channel (valid/ready plus result beat payload).
// Depends on wmin2d_pkg.
`default_nettype none

interface wmin2d_win_if #(
    parameter int VB = wmin2d_pkg::DEF_VALUE_BITS
);
    logic                              valid;
    logic                              ready;
    logic signed [VB-1:0]              window_min;
    logic [wmin2d_pkg::POS_W-1:0]      out_row;
    logic [wmin2d_pkg::POS_W-1:0]      out_col;
    logic                              last;

    modport source (output valid, output window_min, output out_row, output out_col,
                    output last, input ready);
    modport sink   (input valid, input window_min, input out_row, input out_col,
                    input last, output ready);
endinterface

`default_nettype wire

>>> sv/window_min_2d.sv
// window_min_2d: L x L sliding-window minimum over a raster-order square matrix.
// Depends on wmin2d_pkg, wmin2d_pix_if, wmin2d_win_if.
//
//  channel   dir  beat contents                          handshake
//  i_pix     in   pixel, frame_start                     valid/ready
//  o_win     out  window_min, out_row, out_col, last     valid/ready
//  cfg       in   i_cfg_idx, i_cfg_data                  i_cfg_we, no wait
//
// One pixel per cycle unless o_win stalls; results go through stages 1-3 and r4.
// The line store is one word per column holding all row-minima lines; each pixel
// from column L-1 on does one read and one write-back, with forwarding for
// back-to-back hits. Synchronous active-low reset; no clearing pass. A stalled
// output register backs up the pipeline stage by stage, bubbles collapse.
`default_nettype none

module window_min_2d #(
    parameter int MAX_SIZE   = wmin2d_pkg::DEF_MAX_SIZE,
    parameter int MAX_WINDOW = wmin2d_pkg::DEF_MAX_WINDOW,
    parameter int VALUE_BITS = wmin2d_pkg::DEF_VALUE_BITS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [wmin2d_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [wmin2d_pkg::CFG_DATA_W-1:0] i_cfg_data,
    wmin2d_pix_if.sink                            i_pix,
    wmin2d_win_if.source                          o_win
);

    localparam int VB    = VALUE_BITS;
    localparam int PW    = wmin2d_pkg::POS_W;
    localparam int NW    = wmin2d_pkg::IMG_W;
    localparam int LW    = wmin2d_pkg::WIN_W;
    localparam int LINES = (MAX_WINDOW > 1) ? MAX_WINDOW - 1 : 1;
    localparam int SW    = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int AW    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int TL    = 2 ** $clog2(LINES + 1);
    localparam int TD    = $clog2(TL);
    localparam int CUT   = TL >> (TD / 2);
    localparam int MW    = ((SW + 1 > LW) ? SW + 1 : LW) + 1;

    localparam logic signed [VB-1:0] MAXPOS = {1'b0, {(VB-1){1'b1}}};

    // configuration
    logic [NW-1:0] r_img;
    logic [LW-1:0] r_win;
    logic [NW-1:0] n_eff;
    logic [LW-1:0] l_eff;

    // position state
    logic signed [VB-1:0] r_recent [MAX_WINDOW];
    logic [PW-1:0] r_col, r_row;
    logic [SW-1:0] r_slot;

    // line store
    logic [LINES*VB-1:0] r_mem [MAX_SIZE];

    // stage 1
    logic                 r1_v, r1_out, r1_last;
    logic [PW-1:0]        r1_addr, r1_row;
    logic signed [VB-1:0] r1_h [CUT];
    logic [LINES-1:0]     r1_wlane, r1_vmask;
    // stage 2
    logic                 r2_v, r2_out, r2_last, r2_fwd;
    logic [PW-1:0]        r2_addr, r2_row;
    logic signed [VB-1:0] r2_hmin;
    logic [LINES-1:0]     r2_wlane, r2_vmask;
    logic [LINES*VB-1:0]  r2_rdata, r2_fwdw;
    // stage 3
    logic                 r3_v, r3_last;
    logic [PW-1:0]        r3_row, r3_col;
    logic signed [VB-1:0] r3_m [CUT];
    // output register
    logic                 r4_v, r4_last;
    logic [PW-1:0]        r4_row, r4_col;
    logic signed [VB-1:0] r4_min;

    // front-end combinational
    logic                 acc, fs;
    logic [PW-1:0]        col_cur, row_cur;
    logic [SW-1:0]        slot_cur;
    logic [NW-1:0]        col1, row1, cdiff, rdiff;
    logic                 win_ok, row_ok, last_c;
    logic [PW-1:0]        n_col, n_row;
    logic [SW-1:0]        n_slot;
    logic signed [VB-1:0] win_new [MAX_WINDOW];
    logic signed [VB-1:0] h_node [2*TL];
    logic signed [VB-1:0] h2_node [2*CUT];
    logic [LINES-1:0]     wlane_c, vmask_c;
    logic [SW:0]          lane_dist;

    // back-end combinational
    logic [LINES*VB-1:0]  word2, wword;
    logic signed [VB-1:0] v_node [2*TL];
    logic signed [VB-1:0] v2_node [2*CUT];

    // flow control
    logic free4, free3, free2, free1, mv1, mv2, mv3, hit;

    always_comb begin
        n_eff = r_img;
        if (r_img == '0) begin
            n_eff = NW'(1);
        end else if (32'(r_img) > MAX_SIZE) begin
            n_eff = NW'(MAX_SIZE);
        end
        l_eff = r_win;
        if (r_win == '0) begin
            l_eff = LW'(1);
        end else if (32'(r_win) > MAX_WINDOW) begin
            l_eff = LW'(MAX_WINDOW);
        end
        if (NW'(l_eff) > n_eff) begin
            l_eff = n_eff[LW-1:0];
        end
    end

    assign free4 = !r4_v || o_win.ready;
    assign mv3   = r3_v && free4;
    assign free3 = !r3_v || free4;
    assign mv2   = r2_v && (!r2_out || free3);
    assign free2 = !r2_v || mv2;
    assign mv1   = r1_v && free2;
    assign free1 = !r1_v || mv1;
    assign hit   = mv1 && mv2 && (r1_addr == r2_addr);

    assign i_pix.ready = free1;
    assign acc         = i_pix.valid && free1;
    assign fs          = i_pix.frame_start;

    always_comb begin
        col_cur  = fs ? '0 : r_col;
        row_cur  = fs ? '0 : r_row;
        slot_cur = fs ? '0 : r_slot;
        col1     = NW'(col_cur) + NW'(1);
        row1     = NW'(row_cur) + NW'(1);
        win_ok   = col1 >= NW'(l_eff);
        row_ok   = row1 >= NW'(l_eff);
        cdiff    = col1 - NW'(l_eff);
        rdiff    = row1 - NW'(l_eff);
        last_c   = (row1 >= n_eff) && (col1 >= n_eff);
        n_col    = col1[PW-1:0];
        n_row    = row_cur;
        n_slot   = slot_cur;
        if (col1 >= n_eff) begin
            n_col = '0;
            n_row = (row1 >= n_eff) ? '0 : row1[PW-1:0];
            if (n_row == '0) begin
                n_slot = '0;
            end else begin
                n_slot = (slot_cur == SW'(LINES - 1)) ? '0 : slot_cur + SW'(1);
            end
        end
    end

    always_comb begin
        win_new[0] = i_pix.pixel;
        for (int k = 1; k < MAX_WINDOW; k++) begin
            win_new[k] = r_recent[k-1];
        end
        for (int j = 0; j < 2*TL; j++) begin
            h_node[j] = MAXPOS;
        end
        for (int k = 0; k < MAX_WINDOW; k++) begin
            h_node[TL+k] = (k < 32'(l_eff)) ? win_new[k] : MAXPOS;
        end
        for (int j = TL - 1; j >= CUT; j--) begin
            h_node[j] = (h_node[2*j] < h_node[2*j+1]) ? h_node[2*j] : h_node[2*j+1];
        end
    end

    always_comb begin
        lane_dist = '0;
        for (int j = 0; j < LINES; j++) begin
            wlane_c[j] = (slot_cur == SW'(j));
            if (slot_cur >= SW'(j)) begin
                lane_dist = (SW+1)'(slot_cur) - (SW+1)'(j);
            end else begin
                lane_dist = (SW+1)'(slot_cur) + (SW+1)'(LINES) - (SW+1)'(j);
            end
            // own slot still holds the row LINES back until written
            if (lane_dist == '0) begin
                lane_dist = (SW+1)'(LINES);
            end
            vmask_c[j] = MW'(lane_dist) < MW'(l_eff);
        end
    end

    always_comb begin
        for (int j = 0; j < 2*CUT; j++) begin
            h2_node[j] = MAXPOS;
        end
        for (int k = 0; k < CUT; k++) begin
            h2_node[CUT+k] = r1_h[k];
        end
        for (int j = CUT - 1; j >= 1; j--) begin
            h2_node[j] = (h2_node[2*j] < h2_node[2*j+1]) ? h2_node[2*j] : h2_node[2*j+1];
        end
    end

    always_comb begin
        word2 = r2_fwd ? r2_fwdw : r2_rdata;
        for (int j = 0; j < 2*TL; j++) begin
            v_node[j] = MAXPOS;
        end
        v_node[TL] = r2_hmin;
        for (int j = 0; j < LINES; j++) begin
            wword[j*VB +: VB] = r2_wlane[j] ? r2_hmin : word2[j*VB +: VB];
            v_node[TL+1+j]    = r2_vmask[j] ? $signed(word2[j*VB +: VB]) : MAXPOS;
        end
        for (int j = TL - 1; j >= CUT; j--) begin
            v_node[j] = (v_node[2*j] < v_node[2*j+1]) ? v_node[2*j] : v_node[2*j+1];
        end
    end

    always_comb begin
        for (int j = 0; j < 2*CUT; j++) begin
            v2_node[j] = MAXPOS;
        end
        for (int k = 0; k < CUT; k++) begin
            v2_node[CUT+k] = r3_m[k];
        end
        for (int j = CUT - 1; j >= 1; j--) begin
            v2_node[j] = (v2_node[2*j] < v2_node[2*j+1]) ? v2_node[2*j] : v2_node[2*j+1];
        end
    end

    // config and position state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img  <= wmin2d_pkg::IMG_RST;
            r_win  <= wmin2d_pkg::WIN_RST;
            r_col  <= '0;
            r_row  <= '0;
            r_slot <= '0;
            for (int k = 0; k < MAX_WINDOW; k++) begin
                r_recent[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (wmin2d_pkg::t_cfg_reg'(i_cfg_idx))
                    wmin2d_pkg::CFG_IMAGE_SIZE: begin
                        r_img <= i_cfg_data[NW-1:0];
                    end
                    wmin2d_pkg::CFG_WINDOW_SIZE: begin
                        r_win <= i_cfg_data[LW-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (acc) begin
                r_col  <= n_col;
                r_row  <= n_row;
                r_slot <= n_slot;
                for (int k = 0; k < MAX_WINDOW; k++) begin
                    r_recent[k] <= win_new[k];
                end
            end
        end
    end

    // line store: read on entry to stage 2, write back on exit
    always_ff @(posedge i_clk) begin
        if (free2 && mv1) begin
            r2_rdata <= r_mem[AW'(r1_addr)];
        end
        if (mv2) begin
            r_mem[AW'(r2_addr)] <= wword;
        end
    end

    // pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            if (free1) begin
                r1_v <= acc && win_ok;
            end
            if (free2) begin
                r2_v <= mv1;
            end
            if (free3) begin
                r3_v <= mv2 && r2_out;
            end
            if (free4) begin
                r4_v <= mv3;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (free1) begin
            r1_out   <= row_ok;
            r1_last  <= last_c;
            r1_addr  <= cdiff[PW-1:0];
            r1_row   <= rdiff[PW-1:0];
            r1_wlane <= wlane_c;
            r1_vmask <= vmask_c;
            for (int k = 0; k < CUT; k++) begin
                r1_h[k] <= h_node[CUT+k];
            end
        end
        if (free2) begin
            r2_out   <= r1_out;
            r2_last  <= r1_last;
            r2_addr  <= r1_addr;
            r2_row   <= r1_row;
            r2_wlane <= r1_wlane;
            r2_vmask <= r1_vmask;
            r2_hmin  <= h2_node[1];
            r2_fwd   <= hit;
            r2_fwdw  <= wword;
        end
        if (free3) begin
            r3_last <= r2_last;
            r3_row  <= r2_row;
            r3_col  <= r2_addr;
            for (int k = 0; k < CUT; k++) begin
                r3_m[k] <= v_node[CUT+k];
            end
        end
        if (free4) begin
            r4_last <= r3_last;
            r4_row  <= r3_row;
            r4_col  <= r3_col;
            r4_min  <= v2_node[1];
        end
    end

    assign o_win.valid      = r4_v;
    assign o_win.window_min = r4_min;
    assign o_win.out_row    = r4_row;
    assign o_win.out_col    = r4_col;
    assign o_win.last       = r4_last;

endmodule

`default_nettype wire

>>> sim/tb_window_min_2d.sv
// tb_window_min_2d: self-checking bench for the 2-D sliding-window minimum block.
// A scoreboard class predicts every window result from accepted pixel beats;
// depends on wmin2d_pkg, wmin2d_pix_if, wmin2d_win_if and window_min_2d.
`timescale 1ns / 100ps

localparam int LINE_SLOTS = wmin2d_pkg::DEF_MAX_WINDOW - 1;
localparam int POS_BITS   = wmin2d_pkg::POS_W;
localparam int CFG_BITS   = wmin2d_pkg::CFG_DATA_W;

typedef struct packed {
    logic signed [wmin2d_pkg::DEF_VALUE_BITS-1:0] minimum;
    logic [wmin2d_pkg::POS_W-1:0]                 top_row;
    logic [wmin2d_pkg::POS_W-1:0]                 left_col;
    logic                                         last;
} t_window_beat;

class erosion_tracker;
    logic [wmin2d_pkg::IMG_W-1:0]                 image_reg;
    logic [wmin2d_pkg::WIN_W-1:0]                 window_reg;
    logic signed [wmin2d_pkg::DEF_VALUE_BITS-1:0] recent [wmin2d_pkg::DEF_MAX_WINDOW];
    logic signed [wmin2d_pkg::DEF_VALUE_BITS-1:0] row_min [LINE_SLOTS*wmin2d_pkg::DEF_MAX_SIZE];
    bit                                           filled [LINE_SLOTS*wmin2d_pkg::DEF_MAX_SIZE];
    int                                           col;
    int                                           row;
    t_window_beat                                 pending_minima [$];
    int                                           mismatches;

    function new();
        image_reg  = wmin2d_pkg::IMG_RST;
        window_reg = wmin2d_pkg::WIN_RST;
        foreach (recent[k]) recent[k] = '0;
        col        = 0;
        row        = 0;
        mismatches = 0;
    endfunction

    function void write_reg(wmin2d_pkg::t_cfg_reg idx, logic [CFG_BITS-1:0] data);
        if (idx == wmin2d_pkg::CFG_IMAGE_SIZE) begin
            image_reg = data;
        end else begin
            window_reg = data[wmin2d_pkg::WIN_W-1:0];
        end
    endfunction

    // effective size and window after saturation
    function void sizes(output int n, output int l);
        n = image_reg;
        if (n < 1) n = 1;
        if (n > wmin2d_pkg::DEF_MAX_SIZE) n = wmin2d_pkg::DEF_MAX_SIZE;
        l = window_reg;
        if (l < 1) l = 1;
        if (l > wmin2d_pkg::DEF_MAX_WINDOW) l = wmin2d_pkg::DEF_MAX_WINDOW;
        if (l > n) l = n;
    endfunction

    // would this beat read a line-store entry never written since reset?
    function bit reads_unwritten(logic fs);
        int n;
        int l;
        int c;
        int r;
        sizes(n, l);
        c = fs ? 0 : col;
        r = fs ? 0 : row;
        if (c + 1 < l || r + 1 < l) return 1'b0;
        for (int k = 1; k < l; k++) begin
            if (!filled[((r - k) % LINE_SLOTS) * wmin2d_pkg::DEF_MAX_SIZE + c + 1 - l])
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function void take_pixel(logic signed [wmin2d_pkg::DEF_VALUE_BITS-1:0] value, logic fs);
        int                                           n;
        int                                           l;
        int                                           c;
        int                                           slot;
        logic signed [wmin2d_pkg::DEF_VALUE_BITS-1:0] hmin;
        logic signed [wmin2d_pkg::DEF_VALUE_BITS-1:0] vmin;
        t_window_beat                                 w;
        sizes(n, l);
        if (fs) begin
            col = 0;
            row = 0;
        end
        for (int k = wmin2d_pkg::DEF_MAX_WINDOW - 1; k > 0; k--) recent[k] = recent[k-1];
        recent[0] = value;
        if (col + 1 >= l) begin
            c    = col + 1 - l;
            hmin = recent[0];
            for (int k = 1; k < l; k++) if (recent[k] < hmin) hmin = recent[k];
            if (row + 1 >= l) begin
                vmin = hmin;
                for (int k = 1; k < l; k++) begin
                    slot = ((row - k) % LINE_SLOTS) * wmin2d_pkg::DEF_MAX_SIZE + c;
                    if (row_min[slot] < vmin) vmin = row_min[slot];
                end
                w.minimum  = vmin;
                w.top_row  = POS_BITS'(row + 1 - l);
                w.left_col = POS_BITS'(c);
                w.last     = (row + 1 >= n) && (col + 1 >= n);
                pending_minima.insert(pending_minima.size(), w);
            end
            slot          = (row % LINE_SLOTS) * wmin2d_pkg::DEF_MAX_SIZE + c;
            row_min[slot] = hmin;
            filled[slot]  = 1'b1;
        end
        if (col + 1 >= n) begin
            col = 0;
            row = (row + 1 >= n) ? 0 : row + 1;
        end else begin
            col = col + 1;
        end
    endfunction

    function void match_window(t_window_beat got);
        t_window_beat want;
        if (pending_minima.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected window beat: min %0d row %0d col %0d last %0b",
                         got.minimum, got.top_row, got.left_col, got.last);
            return;
        end
        want = pending_minima[0];
        pending_minima.delete(0);
        if (got.minimum !== want.minimum || got.top_row !== want.top_row ||
            got.left_col !== want.left_col || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"window beat mismatch: expected min %0d row %0d col %0d last %0b,",
                          " got min %0d row %0d col %0d last %0b"},
                         want.minimum, want.top_row, want.left_col, want.last,
                         got.minimum, got.top_row, got.left_col, got.last);
        end
    endfunction
endclass

module tb_window_min_2d;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    cfg_we;
    wmin2d_pkg::t_cfg_reg    cfg_idx;
    logic [CFG_BITS-1:0]     cfg_data;
    int                      src_idle;
    int                      snk_idle;
    int                      sent;
    erosion_tracker          sb;

    logic [31:0] frame4 [16] = '{
        32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
        32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0001, 32'hffff_fffe,
        32'h7fff_ffff, 32'h8000_0000, 32'h0000_0005, 32'h0000_0005,
        32'h0000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h8000_0000
    };
    int phase_size [12] = '{5, 1, 8, 16, 0, 20, 1024, 6, 12, 2047, 9, 11};
    int phase_win  [12] = '{3, 1, 16, 16, 0, 5, 1, 31, 34, 0, 4, 11};
    int phase_len  [12] = '{150, 150, 150, 300, 100, 150, 200, 120, 150,
                            100, 150, 150};

    wmin2d_pix_if pix_if ();
    wmin2d_win_if win_if ();

    window_min_2d i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pix      (pix_if),
        .o_win      (win_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("tb_window_min_2d failed");
        $finish;
    end

    always @(posedge i_clk) begin : result_sink
        t_window_beat got;
        if (i_rst_n && win_if.valid && win_if.ready) begin
            got.minimum  = win_if.window_min;
            got.top_row  = win_if.out_row;
            got.left_col = win_if.out_col;
            got.last     = win_if.last;
            sb.match_window(got);
        end
        win_if.ready <= ($urandom_range(99) >= snk_idle);
    end

    function automatic logic [31:0] pick_pixel();
        case ($urandom_range(7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            4, 5:    return $urandom_range(8) - 4;  // small values, many ties
            default: return $urandom();
        endcase
    endfunction

    task automatic send_pixel(input logic [31:0] value, input logic fs);
        logic start;
        start = fs | sb.reads_unwritten(fs);
        while ($urandom_range(99) < src_idle) begin
            pix_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_if.valid       <= 1'b1;
        pix_if.pixel       <= value;
        pix_if.frame_start <= start;
        do @(posedge i_clk); while (!pix_if.ready);
        sb.take_pixel(value, start);
        sent++;
    endtask

    task automatic drain();
        pix_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_minima.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [CFG_BITS-1:0] size,
                              input logic [CFG_BITS-1:0] win);
        cfg_we   <= 1'b1;
        cfg_idx  <= wmin2d_pkg::CFG_IMAGE_SIZE;
        cfg_data <= size;
        @(posedge i_clk);
        sb.write_reg(wmin2d_pkg::CFG_IMAGE_SIZE, size);
        cfg_idx  <= wmin2d_pkg::CFG_WINDOW_SIZE;
        cfg_data <= win;
        @(posedge i_clk);
        sb.write_reg(wmin2d_pkg::CFG_WINDOW_SIZE, win);
        cfg_we   <= 1'b0;
    endtask

    initial begin
        sb                 = new();
        sent               = 0;
        src_idle           = 28;
        snk_idle           = 80;
        pix_if.valid       <= 1'b0;
        pix_if.pixel       <= '0;
        pix_if.frame_start <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_idx            <= wmin2d_pkg::CFG_IMAGE_SIZE;
        cfg_data           <= '0;
        i_rst_n            <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings, first row only
        send_pixel(32'h7fff_ffff, 1'b1);
        send_pixel(32'h8000_0000, 1'b0);
        drain();

        set_config(4, 2);
        foreach (frame4[i]) send_pixel(frame4[i], i == 0);
        drain();

        // one-pixel matrix, wraps without frame start
        set_config(1, 1);
        send_pixel(32'h8000_0000, 1'b0);
        send_pixel(32'h7fff_ffff, 1'b0);
        drain();

        // window saturates to the image size
        set_config(3, 31);
        for (int i = 0; i < 9; i++) send_pixel(pick_pixel(), i == 0);
        drain();

        for (int p = 0; p < 12; p++) begin
            src_idle = (p < 4) ? 28 : (p < 8) ? 80 : 0;
            snk_idle = (p < 4) ? 80 : (p < 8) ? 28 : 0;
            set_config(CFG_BITS'(phase_size[p]), CFG_BITS'(phase_win[p]));
            for (int i = 0; i < phase_len[p]; i++) begin
                logic fs;
                if (p % 3 == 1 && i == phase_len[p] / 2) drain();
                fs = (sb.col == 0 && sb.row == 0) ? ($urandom_range(9) != 0)
                                                  : ($urandom_range(63) == 0);
                send_pixel(pick_pixel(), fs);
            end
            drain();
        end

        if (sb.mismatches == 0 && sb.pending_minima.size() == 0) begin
            $display("tb_window_min_2d passed");
        end else begin
            $display("tb_window_min_2d failed");
        end
        $finish;
    end

endmodule
